// File: hw/rtl/nirle_pkg.sv
// shared types, codes and helpers for the nibble image rle decoder
package nirle_pkg;

  localparam int unsigned PosW  = 18;
  localparam int unsigned RunW  = 17;
  localparam int unsigned UsedW = 20;
  localparam int unsigned OutWW = 10;
  localparam int unsigned OutHW = 9;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_CMD     = 3'd1,
    PH_COUNT1  = 3'd2,
    PH_COUNT2  = 3'd3,
    PH_RUN     = 3'd4,
    PH_LITERAL = 3'd5,
    PH_SKIP    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_SIZE = 3'd1,
    ST_OVER_CAP = 3'd2,
    ST_RUN_OVF  = 3'd3,
    ST_TRUNC    = 3'd4,
    ST_BAD_COPY = 3'd5,
    ST_RESERVED = 3'd6,
    ST_BUSY     = 3'd7
  } status_t;

  localparam logic [1:0] MODE_FILL = 2'd0;
  localparam logic [1:0] MODE_LIT  = 2'd1;
  localparam logic [1:0] MODE_COPY = 2'd3;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [PosW-1:0] CapReset = 18'd256000;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       stream_end;
  } item_t;

  function automatic logic awaiting_byte(phase_t ph, logic lead, logic nib);
    logic r;
    r = (ph == PH_HEADER) || (ph == PH_CMD) || (ph == PH_COUNT1) || (ph == PH_COUNT2) ||
        ((ph == PH_LITERAL) && !lead && !nib);
    return r;
  endfunction

endpackage

// File: hw/rtl/nirle_front.sv
// front queue: takes input beats and holds them for the decode core
module nirle_front import nirle_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_ready,
  output item_t q_item
);

  item_t       ent_r [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = ent_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= in_item;
  end

endmodule

// File: hw/rtl/nirle_core.sv
// decode core: command parsing, run state, line store and result register
module nirle_core import nirle_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 640,
  parameter int unsigned MAX_HEIGHT = 400
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [PosW-1:0]     capacity,
  input  logic                q_valid,
  output logic                q_ready,
  input  item_t               q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_kind,
  output logic [3:0]          out_pixel,
  output logic [PosW-1:0]     out_pixel_index,
  output logic [OutWW-1:0]    out_width,
  output logic [OutHW-1:0]    out_height,
  output logic [2:0]          out_status,
  output logic [UsedW-1:0]    out_bytes_used,
  output logic                out_last
);

  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned COLW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  phase_t            ph_r, ph_nxt;
  logic [2:0]        hc_r, hc_nxt;
  logic [7:0]        chi_r, chi_nxt;
  logic [WW-1:0]     w_r, w_nxt;
  logic [HW-1:0]     h_r, h_nxt;
  logic [PosW-1:0]   tot_r, tot_nxt;
  logic [PosW-1:0]   pos_r, pos_nxt;
  logic [COLW-1:0]   col_r, col_nxt;
  logic [2:0]        mode_r, mode_nxt;
  logic [RunW-1:0]   left_r, left_nxt;
  logic [3:0]        color_r, color_nxt;
  logic [3:0]        held_r, held_nxt;
  logic              nib_r, nib_nxt, lead_r, lead_nxt;
  logic              endf_r, endf_nxt, bad_r, bad_nxt;
  logic [UsedW-1:0]  bseen_r, bseen_nxt;

  logic              ov_r, ov_nxt;
  logic              okind_r, okind_nxt;
  logic [3:0]        opix_r, opix_nxt;
  logic [PosW-1:0]   oidx_r, oidx_nxt;
  logic [OutWW-1:0]  ow_r, ow_nxt;
  logic [OutHW-1:0]  oh_r, oh_nxt;
  status_t           ost_r, ost_nxt;
  logic [UsedW-1:0]  oused_r, oused_nxt;
  logic              olast_r, olast_nxt;

  logic [3:0]        line_mem [MAX_WIDTH];
  logic [3:0]        rd_q;
  logic              we;
  logic [COLW-1:0]   wa;
  logic [3:0]        wd;

  logic              adv, res, fl, emit, restart;
  status_t           fst;
  logic [3:0]        ep;
  logic [15:0]       hv;
  logic [WW+HW-1:0]  prod;
  logic [RunW-1:0]   cnt;
  logic [PosW-1:0]   rem;
  logic [WW:0]       col_inc;

  assign q_ready = !ov_r || out_ready;
  assign adv     = q_valid && q_ready;

  always_comb begin
    ph_nxt = ph_r; hc_nxt = hc_r; chi_nxt = chi_r; w_nxt = w_r; h_nxt = h_r;
    tot_nxt = tot_r; pos_nxt = pos_r; col_nxt = col_r; mode_nxt = mode_r;
    left_nxt = left_r; color_nxt = color_r; held_nxt = held_r; nib_nxt = nib_r;
    lead_nxt = lead_r; endf_nxt = endf_r; bad_nxt = bad_r; bseen_nxt = bseen_r;
    okind_nxt = okind_r; opix_nxt = opix_r; oidx_nxt = oidx_r; ow_nxt = ow_r;
    oh_nxt = oh_r; ost_nxt = ost_r; oused_nxt = oused_r; olast_nxt = olast_r;
    res = 1'b0; fl = 1'b0; fst = ST_OK; emit = 1'b0; ep = 4'd0; restart = 1'b0;
    we = 1'b0; wa = col_r; wd = 4'd0;
    hv = {chi_r, q_item.data_byte};
    prod = '0;
    cnt = '0;
    rem = tot_r - pos_r;
    col_inc = '0;

    if (adv) begin
      if (q_item.op == OP_BYTE) begin
        if (ph_r == PH_SKIP) begin
          if (q_item.stream_end) restart = 1'b1;
        end else begin
          if (q_item.stream_end) endf_nxt = 1'b1;
          if (ph_r == PH_RUN || (ph_r == PH_LITERAL && (lead_r || nib_r))) begin
            fl = 1'b1; fst = ST_BUSY;
          end else begin
            if (bseen_r != '1) bseen_nxt = bseen_r + 1'b1;
            unique case (ph_r)
              PH_HEADER: begin
                if (hc_r == 3'd0 || hc_r == 3'd2) begin
                  chi_nxt = q_item.data_byte;
                end else if (hc_r == 3'd1) begin
                  if (hv == 16'd0 || hv > 16'(MAX_WIDTH)) bad_nxt = 1'b1;
                  else w_nxt = hv[WW-1:0];
                end else begin
                  if (hv == 16'd0 || hv > 16'(MAX_HEIGHT)) bad_nxt = 1'b1;
                  else h_nxt = hv[HW-1:0];
                end
                hc_nxt = hc_r + 3'd1;
                if (hc_nxt >= 3'd4) begin
                  prod = (WW+HW)'(w_nxt) * (WW+HW)'(h_nxt);
                  if (bad_nxt) begin
                    w_nxt = '0; h_nxt = '0; fl = 1'b1; fst = ST_BAD_SIZE;
                  end else if ((WW+HW+PosW)'(prod) > (WW+HW+PosW)'(capacity)) begin
                    w_nxt = '0; h_nxt = '0; fl = 1'b1; fst = ST_OVER_CAP;
                  end else begin
                    tot_nxt = PosW'(prod);
                    ph_nxt = PH_CMD;
                  end
                end
              end
              PH_CMD: begin
                color_nxt = q_item.data_byte[3:0];
                if (!q_item.data_byte[7]) begin
                  cnt = RunW'(q_item.data_byte[6:4]) + 1'b1;
                  if (PosW'(cnt) > rem) begin
                    fl = 1'b1; fst = ST_RUN_OVF;
                  end else begin
                    mode_nxt = 3'd0; left_nxt = cnt; ph_nxt = PH_RUN;
                  end
                end else begin
                  mode_nxt = q_item.data_byte[6:4];
                  ph_nxt = PH_COUNT1;
                end
              end
              PH_COUNT1, PH_COUNT2: begin
                if (ph_r == PH_COUNT1 && mode_r[2]) begin
                  chi_nxt = q_item.data_byte;
                  ph_nxt = PH_COUNT2;
                end else begin
                  if (ph_r == PH_COUNT2) cnt = RunW'(hv) + 1'b1;
                  else cnt = RunW'(q_item.data_byte) + 1'b1;
                  // long command start
                  unique case (mode_r[1:0])
                    MODE_FILL: begin
                      if (PosW'(cnt) > rem) begin fl = 1'b1; fst = ST_RUN_OVF; end
                      else begin left_nxt = cnt; ph_nxt = PH_RUN; end
                    end
                    MODE_LIT: begin
                      if (PosW'(cnt) > rem) begin fl = 1'b1; fst = ST_RUN_OVF; end
                      else begin
                        lead_nxt = cnt[0];
                        left_nxt = cnt >> 1;
                        ph_nxt = PH_LITERAL;
                      end
                    end
                    MODE_COPY: begin
                      if (PosW'(cnt) >= rem || pos_r < PosW'(w_r) ||
                          PosW'(cnt) > PosW'(col_r) + PosW'(w_r)) begin
                        fl = 1'b1; fst = ST_BAD_COPY;
                      end else begin
                        left_nxt = cnt + 1'b1; ph_nxt = PH_RUN;
                      end
                    end
                    default: begin
                      fl = 1'b1; fst = ST_RESERVED;
                    end
                  endcase
                end
              end
              default: begin
                // literal pair byte
                color_nxt = q_item.data_byte[7:4];
                lead_nxt = 1'b1;
                held_nxt = q_item.data_byte[3:0];
                nib_nxt = 1'b1;
                if (left_r != '0) left_nxt = left_r - 1'b1;
              end
            endcase
            if (!fl && awaiting_byte(ph_nxt, lead_nxt, nib_nxt) && endf_nxt) begin
              fl = 1'b1; fst = ST_TRUNC;
            end
          end
        end
      end else begin
        if (ph_r == PH_RUN) begin
          if (mode_r[1:0] == MODE_COPY && left_r != RunW'(1)) ep = rd_q;
          else ep = color_r;
          if (left_r != '0) left_nxt = left_r - 1'b1;
          emit = 1'b1;
        end else if (ph_r == PH_LITERAL && (lead_r || nib_r)) begin
          if (lead_r) begin ep = color_r; lead_nxt = 1'b0; end
          else begin ep = held_r; nib_nxt = 1'b0; end
          emit = 1'b1;
        end else if (ph_r != PH_SKIP && awaiting_byte(ph_r, lead_r, nib_r) && endf_r) begin
          fl = 1'b1; fst = ST_TRUNC;
        end
      end
    end

    if (emit) begin
      we = 1'b1; wa = col_r; wd = ep;
      res = 1'b1;
      okind_nxt = 1'b0; opix_nxt = ep; oidx_nxt = pos_r;
      ow_nxt = OutWW'(w_r); oh_nxt = OutHW'(h_r);
      ost_nxt = ST_OK; oused_nxt = '0; olast_nxt = 1'b0;
      pos_nxt = pos_r + 1'b1;
      col_inc = (WW+1)'(col_r) + 1'b1;
      col_nxt = (col_inc >= (WW+1)'(w_r)) ? '0 : COLW'(col_inc);
      if (pos_nxt >= tot_r) begin
        oused_nxt = bseen_r; olast_nxt = 1'b1;
        if (endf_nxt) restart = 1'b1;
        else ph_nxt = PH_SKIP;
      end else if (ph_r == PH_RUN && left_nxt == '0) begin
        ph_nxt = PH_CMD;
      end else if (ph_r == PH_LITERAL && !lead_nxt && !nib_nxt && left_nxt == '0) begin
        ph_nxt = PH_CMD;
      end
    end

    if (fl) begin
      res = 1'b1;
      okind_nxt = 1'b1; opix_nxt = 4'd0; oidx_nxt = pos_r;
      ow_nxt = OutWW'(w_nxt); oh_nxt = OutHW'(h_nxt);
      ost_nxt = fst; oused_nxt = '0; olast_nxt = 1'b1;
      if (endf_nxt) restart = 1'b1;
      else ph_nxt = PH_SKIP;
    end

    if (restart) begin
      ph_nxt = PH_HEADER; hc_nxt = '0; chi_nxt = '0; w_nxt = '0; h_nxt = '0;
      tot_nxt = '0; pos_nxt = '0; col_nxt = '0; mode_nxt = '0; left_nxt = '0;
      color_nxt = '0; held_nxt = '0; nib_nxt = 1'b0; lead_nxt = 1'b0;
      endf_nxt = 1'b0; bad_nxt = 1'b0; bseen_nxt = '0;
    end

    if (res) ov_nxt = 1'b1;
    else if (out_ready) ov_nxt = 1'b0;
    else ov_nxt = ov_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_HEADER; hc_r <= '0; chi_r <= '0; w_r <= '0; h_r <= '0;
      tot_r <= '0; pos_r <= '0; col_r <= '0; mode_r <= '0; left_r <= '0;
      color_r <= '0; held_r <= '0; nib_r <= 1'b0; lead_r <= 1'b0;
      endf_r <= 1'b0; bad_r <= 1'b0; bseen_r <= '0; ov_r <= 1'b0;
    end else begin
      ph_r <= ph_nxt; hc_r <= hc_nxt; chi_r <= chi_nxt; w_r <= w_nxt; h_r <= h_nxt;
      tot_r <= tot_nxt; pos_r <= pos_nxt; col_r <= col_nxt; mode_r <= mode_nxt;
      left_r <= left_nxt; color_r <= color_nxt; held_r <= held_nxt; nib_r <= nib_nxt;
      lead_r <= lead_nxt; endf_r <= endf_nxt; bad_r <= bad_nxt; bseen_r <= bseen_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    okind_r <= okind_nxt; opix_r <= opix_nxt; oidx_r <= oidx_nxt; ow_r <= ow_nxt;
    oh_r <= oh_nxt; ost_r <= ost_nxt; oused_r <= oused_nxt; olast_r <= olast_nxt;
  end

  // prefetch the entry under the next column, forwarding a same-address write
  always_ff @(posedge clk) begin
    if (we) line_mem[wa] <= wd;
    if (we && wa == col_nxt) rd_q <= wd;
    else rd_q <= line_mem[col_nxt];
  end

  assign out_valid       = ov_r;
  assign out_kind        = okind_r;
  assign out_pixel       = opix_r;
  assign out_pixel_index = oidx_r;
  assign out_width       = ow_r;
  assign out_height      = oh_r;
  assign out_status      = ost_r;
  assign out_bytes_used  = oused_r;
  assign out_last        = olast_r;

endmodule

// File: hw/rtl/nibble_image_rle_decoder_unit.sv
// top level of the nibble image run-length decoder
// usage:
//   the input channel carries stream bytes (in_op 0) and drain ticks (in_op 1).
//   the first four bytes give big-endian width and height; command bytes follow.
//   each drain tick returns one pixel beat while pixels are pending, else an error or nothing.
//   errors come out as a beat with out_kind 1 and out_last set.
//   the final pixel of an image carries out_last and the byte count.
// timing:
//   an accepted beat enters a two-entry queue, then the decode core, then the
//   result register.
//   one item per cycle sustained; the core advances whenever the result
//   register is empty or being taken in the same cycle.
// stall: when out_ready is low the result is held and the core waits; the
//   queue still takes up to two more beats before in_ready drops.
// reset: rst_n (synchronous) returns to header wait, clears the queue and
//   sets pixel_capacity to 256000; the line store holds no reset value.
// config: pixel_capacity at byte address 0; write it only while idle (not enforced).
module nibble_image_rle_decoder_unit import nirle_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 640,
  parameter int unsigned MAX_HEIGHT = 400
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_op,
  input  logic [7:0]        in_data_byte,
  input  logic              in_stream_end,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic [3:0]        out_pixel,
  output logic [PosW-1:0]   out_pixel_index,
  output logic [OutWW-1:0]  out_width,
  output logic [OutHW-1:0]  out_height,
  output logic [2:0]        out_status,
  output logic [UsedW-1:0]  out_bytes_used,
  output logic              out_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [PosW-1:0] cap_r, cap_nxt;
  item_t           in_item, q_item;
  logic            q_valid, q_ready;

  assign in_item = '{op: in_op, data_byte: in_data_byte, stream_end: in_stream_end};
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == 1'b0) ? 32'(cap_r) : 32'd0;

  always_comb begin
    cap_nxt = cap_r;
    if (psel && penable && pwrite && !paddr[2]) cap_nxt = pwdata[PosW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= CapReset;
    else cap_r <= cap_nxt;
  end

  nirle_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item)
  );

  nirle_core #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .capacity       (cap_r),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_item         (q_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_pixel      (out_pixel),
    .out_pixel_index(out_pixel_index),
    .out_width      (out_width),
    .out_height     (out_height),
    .out_status     (out_status),
    .out_bytes_used (out_bytes_used),
    .out_last       (out_last)
  );

endmodule

// File: hw/rtl/nirle_checker.sv
// port-level checks for the decoder top level
module nirle_checker import nirle_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_kind,
  input logic [3:0]        out_pixel,
  input logic [2:0]        out_status,
  input logic [UsedW-1:0]  out_bytes_used,
  input logic              out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_last))
    else $error("result beat changed while stalled");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_last && out_pixel == 4'd0 && out_bytes_used == '0)
    else $error("error beat malformed");

  a_pix_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> out_status == 3'(ST_OK))
    else $error("pixel beat with nonzero status");

  a_used_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bytes_used != '0 |-> out_last && !out_kind)
    else $error("byte count outside final pixel");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind nibble_image_rle_decoder_unit nirle_checker u_nirle_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_kind      (out_kind),
  .out_pixel     (out_pixel),
  .out_status    (out_status),
  .out_bytes_used(out_bytes_used),
  .out_last      (out_last)
);
